@@ hdl/pcc_pkg.sv @@
// Shared types, constants and the arctangent table of the polar to cartesian converter.
package pcc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = CORDIC_STAGES + 3;
    localparam int CNT_W         = $clog2(LATENCY + 1);
    localparam int SHIFT_W       = 5;

    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

    localparam logic MODE_CARTESIAN = 1'b0;
    localparam logic MODE_POLAR     = 1'b1;

    typedef struct packed {
        logic signed [15:0] first_value;
        logic signed [15:0] second_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
    } t_out_beat;

    typedef struct packed {
        logic               valid;
        logic               bypass;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    function automatic logic signed [31:0] pcc_atan(input logic [SHIFT_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/pcc_front.sv @@
// Front end: gain multiply, angle reduction and quadrant step ahead of the rotation cells.
module pcc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_mode,
    input  pcc_pkg::t_in_beat i_in,
    output pcc_pkg::t_vec     o_vec
);
    import pcc_pkg::*;

    logic               r_a_valid;
    logic               r_a_bypass;
    logic signed [46:0] r_a_prod;
    logic signed [31:0] r_a_z;
    logic signed [15:0] r_a_first;
    logic signed [15:0] r_a_second;

    logic signed [46:0] n_a_prod;
    logic signed [31:0] w_z_raw;
    logic signed [31:0] n_a_z;
    logic signed [31:0] w_x0;
    t_vec               r_vec;
    t_vec               n_vec;

    assign n_a_prod = 47'(i_in.first_value) * 47'(GAIN_Q30);
    assign w_z_raw  = $signed({i_in.second_value[15], i_in.second_value, 15'b0});

    always_comb begin
        if (w_z_raw > PI_Q28) begin
            n_a_z = w_z_raw - TWO_PI_Q28;
        end else if (w_z_raw < -PI_Q28) begin
            n_a_z = w_z_raw + TWO_PI_Q28;
        end else begin
            n_a_z = w_z_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_bypass <= (i_mode == MODE_CARTESIAN);
        r_a_prod   <= n_a_prod;
        r_a_z      <= n_a_z;
        r_a_first  <= i_in.first_value;
        r_a_second <= i_in.second_value;
    end

    assign w_x0 = 32'($signed(r_a_prod[45:16]));

    always_comb begin
        n_vec.valid  = r_a_valid;
        n_vec.bypass = r_a_bypass;
        if (r_a_bypass) begin
            n_vec.x = 32'($signed({r_a_first, 14'b0}));
            n_vec.y = 32'($signed({r_a_second, 14'b0}));
            n_vec.z = '0;
        end else if (r_a_z > HALF_PI_Q28) begin
            n_vec.x = '0;
            n_vec.y = w_x0;
            n_vec.z = r_a_z - HALF_PI_Q28;
        end else if (r_a_z < -HALF_PI_Q28) begin
            n_vec.x = '0;
            n_vec.y = -w_x0;
            n_vec.z = r_a_z + HALF_PI_Q28;
        end else begin
            n_vec.x = w_x0;
            n_vec.y = '0;
            n_vec.z = r_a_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec <= '0;
        end else begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

@@ hdl/pcc_cell.sv @@
// One CORDIC micro-rotation cell with its output register.
module pcc_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [pcc_pkg::SHIFT_W-1:0]    i_shift,
    input  logic signed [31:0]             i_atan,
    input  pcc_pkg::t_vec                  i_vec,
    output pcc_pkg::t_vec                  o_vec
);
    import pcc_pkg::*;

    logic signed [31:0] w_dx;
    logic signed [31:0] w_dy;
    t_vec               r_vec;
    t_vec               n_vec;

    assign w_dx = i_vec.y >>> i_shift;
    assign w_dy = i_vec.x >>> i_shift;

    always_comb begin
        n_vec = i_vec;
        if (!i_vec.bypass) begin
            if (!i_vec.z[31]) begin
                n_vec.x = i_vec.x - w_dx;
                n_vec.y = i_vec.y + w_dy;
                n_vec.z = i_vec.z - i_atan;
            end else begin
                n_vec.x = i_vec.x + w_dx;
                n_vec.y = i_vec.y - w_dy;
                n_vec.z = i_vec.z + i_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec <= '0;
        end else begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

@@ hdl/pcc_back.sv @@
// Back end: round to Q8.8, saturate and drive the result beat.
module pcc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcc_pkg::t_vec      i_vec,
    output logic               o_strobe,
    output pcc_pkg::t_out_beat o_out
);
    import pcc_pkg::*;

    function automatic logic signed [15:0] round_sat(input logic signed [31:0] v);
        logic signed [32:0] sum;
        logic signed [32:0] q;
        logic signed [15:0] res;
        sum = 33'(v) + 33'sd8192;
        q   = sum >>> 14;
        if (q > 33'sd32767) begin
            res = 16'sh7FFF;
        end else if (q < -33'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = q[15:0];
        end
        return res;
    endfunction

    logic      r_strobe;
    t_out_beat r_out;
    t_out_beat n_out;

    assign n_out.x_coord = round_sat(i_vec.x);
    assign n_out.y_coord = round_sat(i_vec.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vec.valid;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

@@ hdl/polar_to_cartesian_converter_core.sv @@
// Top level of the polar to cartesian converter: mode register, front end, cell row, back end.
//
// Input channel: a beat (first_value, second_value) is taken at a rising edge with start high
// and busy low. busy stays low, so a beat can enter in every cycle.
// Result channel: o_strobe marks o_out for exactly one cycle; the receiver cannot stall it.
// Config channel: i_cfg_data bit 0 selects the mode (0 pass the pair through, 1 convert
// radius and angle). It is written when i_cfg_valid and o_cfg_ready are both high;
// o_cfg_ready is high only while no beat is in flight.
// Pipeline: one gain multiply stage, one quadrant stage, one cell per micro-rotation, one
// rounding stage, each registered. Throughput: one beat per cycle, set by the fully pipelined
// cell row.
// Both modes run down the same pipeline, so results leave in the order beats came in.
// Reset: synchronous; drops every beat in flight and returns the mode to pass-through.
module polar_to_cartesian_converter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pcc_pkg::t_in_beat  i_in,
    output logic               o_strobe,
    output pcc_pkg::t_out_beat o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import pcc_pkg::*;

    logic             r_mode;
    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;
    logic             w_accept;
    t_vec             w_chain [0:CORDIC_STAGES];

    assign busy        = 1'b0;
    assign w_accept    = start && !busy;
    assign o_cfg_ready = (r_inflight == '0);

    always_comb begin
        n_inflight = r_inflight;
        if (w_accept && !o_strobe) begin
            n_inflight = r_inflight + CNT_W'(1);
        end else if (!w_accept && o_strobe) begin
            n_inflight = r_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_CARTESIAN;
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    pcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_mode  (r_mode),
        .i_in    (i_in),
        .o_vec   (w_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        pcc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHIFT_W'(g)),
            .i_atan  (pcc_atan(SHIFT_W'(g))),
            .i_vec   (w_chain[g]),
            .o_vec   (w_chain[g+1])
        );
    end

    pcc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vec    (w_chain[CORDIC_STAGES]),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

@@ hdl/pcc_checker.sv @@
// Port-level checker for the converter core and its bind to the top level.
module pcc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input pcc_pkg::t_in_beat  i_in,
    input logic               o_strobe,
    input pcc_pkg::t_out_beat o_out,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic               i_cfg_data
);
    import pcc_pkg::*;

    logic r_mode;
    logic w_accept;

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CARTESIAN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    a_strobe_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching input beat");

    a_beat_gives_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_strobe)
        else $error("input beat produced no result");

    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == MODE_CARTESIAN) |-> ##LATENCY
        (o_out.x_coord == $past(i_in.first_value, LATENCY) &&
         o_out.y_coord == $past(i_in.second_value, LATENCY)))
        else $error("pass-through result differs from input");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_cfg_ready)
        else $error("config ready while a beat is in flight");

endmodule

bind polar_to_cartesian_converter_core pcc_checker u_pcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_in        (i_in),
    .o_strobe    (o_strobe),
    .o_out       (o_out),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

@@ tb/sv/polar_to_cartesian_converter_core_tb.sv @@
// Self-checking testbench of the polar to cartesian converter core.
module polar_to_cartesian_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    localparam longint ANGLE_PI      = 843314857;
    localparam longint ANGLE_TWO_PI  = 1686629713;
    localparam longint ANGLE_HALF_PI = 421657428;
    localparam longint CORDIC_GAIN   = 652032874;
    localparam int     ATAN_LEN      = 24;
    localparam longint ATAN_Q28 [ATAN_LEN] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };
    localparam shortint HALF_PI_CODE = 16'sd12868;
    localparam shortint PI_CODE      = 16'sd25736;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_beat  i_in;
    logic      o_strobe;
    t_out_beat o_out;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_data;

    t_out_beat point_q[$];
    logic      mode_q;
    logic      no_idle;
    int        mismatch_cnt;

    polar_to_cartesian_converter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [15:0] q88_sat(input longint v);
        longint r;
        r = (v + 64'sd8192) >>> 14;
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32768) begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    function automatic t_out_beat convert_pair(input t_in_beat b, input logic m);
        t_out_beat pt;
        longint    r;
        longint    z;
        longint    x;
        longint    y;
        longint    x0;
        longint    dx;
        longint    dy;
        if (m == MODE_CARTESIAN) begin
            pt.x_coord = b.first_value;
            pt.y_coord = b.second_value;
            return pt;
        end
        r = b.first_value;
        z = longint'(b.second_value) * 32768;
        if (z > ANGLE_PI) begin
            z -= ANGLE_TWO_PI;
        end else if (z < -ANGLE_PI) begin
            z += ANGLE_TWO_PI;
        end
        x0 = (r * CORDIC_GAIN) >>> 16;
        if (z > ANGLE_HALF_PI) begin
            x = 0;
            y = x0;
            z -= ANGLE_HALF_PI;
        end else if (z < -ANGLE_HALF_PI) begin
            x = 0;
            y = -x0;
            z += ANGLE_HALF_PI;
        end else begin
            x = x0;
            y = 0;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ATAN_Q28[i];
            end else begin
                x += dx;
                y -= dy;
                z += ATAN_Q28[i];
            end
        end
        pt.x_coord = q88_sat(x);
        pt.y_coord = q88_sat(y);
        return pt;
    endfunction

    function automatic t_in_beat pair(input shortint a, input shortint b);
        t_in_beat p;
        p.first_value  = a;
        p.second_value = b;
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic shortint pick_radius();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return shortint'(256 * $urandom_range(0, 4));
            default: return shortint'($urandom);
        endcase
    endfunction

    function automatic shortint pick_angle();
        shortint nudge;
        nudge = shortint'($urandom_range(0, 2)) - 16'sd1;
        case ($urandom_range(0, 11))
            0:       return HALF_PI_CODE + nudge;
            1:       return -HALF_PI_CODE + nudge;
            2:       return PI_CODE + nudge;
            3:       return -PI_CODE + nudge;
            4:       return nudge;
            default: return shortint'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
        mismatch_cnt++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        if (i_rst_n && o_strobe) begin
            if (point_q.size() == 0) begin
                flag_mismatch("unexpected beat x_coord", o_out.x_coord, 16'sd0);
            end else begin
                want = point_q.pop_front();
                if (o_out.x_coord !== want.x_coord) begin
                    flag_mismatch("x_coord", o_out.x_coord, want.x_coord);
                end
                if (o_out.y_coord !== want.y_coord) begin
                    flag_mismatch("y_coord", o_out.y_coord, want.y_coord);
                end
            end
        end
    end

    task automatic send_pair(input t_in_beat b);
        int gap;
        start <= 1'b1;
        i_in  <= b;
        do @(posedge i_clk); while (busy);
        point_q.push_back(convert_pair(b, mode_q));
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            i_in  <= t_in_beat'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_stream();
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (point_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_mode(input logic m);
        stop_stream();
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        mode_q = m;
        i_cfg_valid <= 1'b0;
    endtask

    // Mode out of reset is pass-through.
    task automatic test_passthrough_extremes();
        send_pair(pair(16'sh7fff, 16'sh8000));
        send_pair(pair(16'sh8000, 16'sh7fff));
        send_pair(pair(16'sd0, 16'sd0));
        send_pair(pair(-16'sd1, -16'sd1));
        send_pair(pair(16'sh5555, 16'shaaaa));
        send_pair(pair(16'shaaaa, 16'sh5555));
        stop_stream();
    endtask

    task automatic test_polar_corners();
        set_mode(MODE_POLAR);
        send_pair(pair(16'sd256, 16'sd0));
        send_pair(pair(16'sd256, HALF_PI_CODE - 16'sd1));
        send_pair(pair(16'sd256, HALF_PI_CODE));
        send_pair(pair(16'sd256, -HALF_PI_CODE + 16'sd1));
        send_pair(pair(16'sd256, -HALF_PI_CODE));
        send_pair(pair(16'sd256, PI_CODE - 16'sd1));
        send_pair(pair(16'sd256, PI_CODE));
        send_pair(pair(16'sd256, -PI_CODE + 16'sd1));
        send_pair(pair(16'sd256, -PI_CODE));
        send_pair(pair(16'sd256, 16'sh8000));
        send_pair(pair(16'sd256, 16'sh7fff));
        send_pair(pair(16'sh7fff, 16'sd0));
        send_pair(pair(16'sh8000, 16'sd0));
        send_pair(pair(16'sh8000, PI_CODE - 16'sd1));
        send_pair(pair(16'sh7fff, 16'sd6434));
        send_pair(pair(16'sd0, 16'sh7fff));
        send_pair(pair(-16'sd1, -16'sd1));
        send_pair(pair(16'sh7fff, 16'sh8000));
        stop_stream();
    endtask

    task automatic test_polar_random(input int n);
        set_mode(MODE_POLAR);
        repeat (n) begin
            send_pair(pair(pick_radius(), pick_angle()));
        end
        stop_stream();
    endtask

    task automatic test_passthrough_random(input int n);
        set_mode(MODE_CARTESIAN);
        repeat (n) begin
            send_pair(t_in_beat'($urandom));
        end
        stop_stream();
    endtask

    // Alternate modes; every other pair of phases runs back to back.
    task automatic test_mode_switching(input int phases, input int n);
        for (int p = 0; p < phases; p++) begin
            set_mode(p[0] ? MODE_CARTESIAN : MODE_POLAR);
            no_idle = p[1];
            repeat (n) begin
                if (mode_q == MODE_POLAR) begin
                    send_pair(pair(pick_radius(), pick_angle()));
                end else begin
                    send_pair(t_in_beat'($urandom));
                end
            end
            stop_stream();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_in         <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= 1'b0;
        mode_q       = MODE_CARTESIAN;
        no_idle      = 1'b0;
        mismatch_cnt = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough_extremes();
        test_polar_corners();
        test_polar_random(300);
        test_passthrough_random(150);
        test_mode_switching(8, 50);

        stop_stream();
        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("polar_to_cartesian_converter_core regression: pass");
        end else begin
            $display("polar_to_cartesian_converter_core regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[%0t] timeout, %0d beats outstanding", $realtime, point_q.size());
        $display("polar_to_cartesian_converter_core regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pcc_pkg.sv
hdl/pcc_front.sv
hdl/pcc_cell.sv
hdl/pcc_back.sv
hdl/polar_to_cartesian_converter_core.sv
hdl/pcc_checker.sv
tb/sv/polar_to_cartesian_converter_core_tb.sv
